FILE: design/kpr_pkg.sv
// ----------------------------------------------------------------------------
// kpr_pkg
// Shared types, codes and the evaluation microprogram of the keypoint
// refinement filter.
// ----------------------------------------------------------------------------
package kpr_pkg;

  localparam int NUM_SAMPLES = 25;
  localparam int PROG_LEN    = 65;
  localparam int PC_BITS     = 7;
  localparam int EDGE_BITS   = 16;
  localparam int CON_BITS    = 15;
  localparam int QUOT_BITS   = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_EDGE     = 2'd0;
  localparam logic [1:0] CFG_CONTRAST = 2'd1;

  // outcome codes
  localparam logic [1:0] OUT_KEPT  = 2'd0;
  localparam logic [1:0] OUT_EDGE  = 2'd1;
  localparam logic [1:0] OUT_LOWC  = 2'd2;
  localparam logic [1:0] OUT_PIVOT = 2'd3;

  // microinstruction opcodes
  localparam logic [2:0] OP_CLR  = 3'd0;
  localparam logic [2:0] OP_MAC  = 3'd1;
  localparam logic [2:0] OP_STO  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_EMIT = 3'd4;

  // operand sources: narrow sums, then wide registers, then scaled trace
  localparam logic [4:0] SRC_DXX  = 5'd0;
  localparam logic [4:0] SRC_DYY  = 5'd1;
  localparam logic [4:0] SRC_DXY  = 5'd2;
  localparam logic [4:0] SRC_DXS  = 5'd3;
  localparam logic [4:0] SRC_DYS  = 5'd4;
  localparam logic [4:0] SRC_DSS  = 5'd5;
  localparam logic [4:0] SRC_B0   = 5'd6;
  localparam logic [4:0] SRC_B1   = 5'd7;
  localparam logic [4:0] SRC_B2   = 5'd8;
  localparam logic [4:0] SRC_TR   = 5'd9;
  localparam logic [4:0] SRC_ET   = 5'd10;
  localparam logic [4:0] SRC_S0X2 = 5'd11;
  localparam logic [4:0] SRC_B0X2 = 5'd12;
  localparam logic [4:0] SRC_B1X2 = 5'd13;
  localparam logic [4:0] SRC_D2   = 5'd16;
  localparam logic [4:0] SRC_A00  = 5'd17;
  localparam logic [4:0] SRC_A11  = 5'd18;
  localparam logic [4:0] SRC_A01  = 5'd19;
  localparam logic [4:0] SRC_A02  = 5'd20;
  localparam logic [4:0] SRC_A12  = 5'd21;
  localparam logic [4:0] SRC_D3   = 5'd22;
  localparam logic [4:0] SRC_TRSH = 5'd24;

  // wide register file slots
  localparam int R_COUNT = 7;
  localparam logic [2:0] R_D2  = 3'd0;
  localparam logic [2:0] R_A00 = 3'd1;
  localparam logic [2:0] R_A11 = 3'd2;
  localparam logic [2:0] R_A01 = 3'd3;
  localparam logic [2:0] R_A02 = 3'd4;
  localparam logic [2:0] R_A12 = 3'd5;
  localparam logic [2:0] R_D3  = 3'd6;

  // emit conditions
  localparam logic [2:0] CND_ALWAYS   = 3'd0;
  localparam logic [2:0] CND_FLAT     = 3'd1;
  localparam logic [2:0] CND_EDGE     = 3'd2;
  localparam logic [2:0] CND_PIVOT    = 3'd3;
  localparam logic [2:0] CND_ACC_ZERO = 3'd4;
  localparam logic [2:0] CND_K_LOW    = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] src;
    logic [3:0] msel;
    logic       neg;
    logic [2:0] dst;
    logic [2:0] cond;
    logic [1:0] code;
  } instr_t;

  typedef struct packed {
    logic   go;
    logic   load_out;
    instr_t ins;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic acc_zero;
    logic acc_neg;
    logic d2_zero;
    logic d2_pos;
    logic tr_nz;
    logic dxx_zero;
    logic k_low;
  } status_t;

  function automatic instr_t i_clr();
    instr_t r;
    r = '0;
    r.op = OP_CLR;
    return r;
  endfunction

  function automatic instr_t i_mac(input logic [4:0] src, input logic [4:0] msel,
                                   input logic neg);
    instr_t r;
    r = '0;
    r.op   = OP_MAC;
    r.src  = src;
    r.msel = msel[3:0];
    r.neg  = neg;
    return r;
  endfunction

  function automatic instr_t i_sto(input logic [2:0] dst);
    instr_t r;
    r = '0;
    r.op  = OP_STO;
    r.dst = dst;
    return r;
  endfunction

  function automatic instr_t i_div();
    instr_t r;
    r = '0;
    r.op = OP_DIV;
    return r;
  endfunction

  function automatic instr_t i_emit(input logic [2:0] cond, input logic [1:0] code);
    instr_t r;
    r = '0;
    r.op   = OP_EMIT;
    r.cond = cond;
    r.code = code;
    return r;
  endfunction

  // Evaluation program: edge test, adjugate, determinant, quadratic form,
  // division and contrast check.
  function automatic instr_t prog(input logic [PC_BITS-1:0] pc);
    instr_t r;
    unique case (pc)
      7'd0:  r = i_clr();
      7'd1:  r = i_mac(SRC_DYY, SRC_DXX, 1'b0);
      7'd2:  r = i_mac(SRC_DXY, SRC_DXY, 1'b1);
      7'd3:  r = i_sto(R_D2);
      7'd4:  r = i_emit(CND_FLAT, OUT_EDGE);
      7'd5:  r = i_clr();
      7'd6:  r = i_mac(SRC_TRSH, SRC_TR, 1'b0);
      7'd7:  r = i_mac(SRC_D2, SRC_ET, 1'b1);
      7'd8:  r = i_emit(CND_EDGE, OUT_EDGE);
      7'd9:  r = i_emit(CND_PIVOT, OUT_PIVOT);
      7'd10: r = i_clr();
      7'd11: r = i_mac(SRC_DSS, SRC_DYY, 1'b0);
      7'd12: r = i_mac(SRC_DYS, SRC_DYS, 1'b1);
      7'd13: r = i_sto(R_A00);
      7'd14: r = i_clr();
      7'd15: r = i_mac(SRC_DSS, SRC_DXX, 1'b0);
      7'd16: r = i_mac(SRC_DXS, SRC_DXS, 1'b1);
      7'd17: r = i_sto(R_A11);
      7'd18: r = i_clr();
      7'd19: r = i_mac(SRC_DYS, SRC_DXS, 1'b0);
      7'd20: r = i_mac(SRC_DSS, SRC_DXY, 1'b1);
      7'd21: r = i_sto(R_A01);
      7'd22: r = i_clr();
      7'd23: r = i_mac(SRC_DYS, SRC_DXY, 1'b0);
      7'd24: r = i_mac(SRC_DYY, SRC_DXS, 1'b1);
      7'd25: r = i_sto(R_A02);
      7'd26: r = i_clr();
      7'd27: r = i_mac(SRC_DXS, SRC_DXY, 1'b0);
      7'd28: r = i_mac(SRC_DYS, SRC_DXX, 1'b1);
      7'd29: r = i_sto(R_A12);
      7'd30: r = i_clr();
      7'd31: r = i_mac(SRC_A00, SRC_DXX, 1'b0);
      7'd32: r = i_mac(SRC_A01, SRC_DXY, 1'b0);
      7'd33: r = i_mac(SRC_A02, SRC_DXS, 1'b0);
      7'd34: r = i_sto(R_D3);
      7'd35: r = i_emit(CND_ACC_ZERO, OUT_PIVOT);
      7'd36: r = i_clr();
      7'd37: r = i_mac(SRC_A00, SRC_B0, 1'b0);
      7'd38: r = i_sto(R_A00);
      7'd39: r = i_clr();
      7'd40: r = i_mac(SRC_A11, SRC_B1, 1'b0);
      7'd41: r = i_sto(R_A11);
      7'd42: r = i_clr();
      7'd43: r = i_mac(SRC_D2, SRC_B2, 1'b0);
      7'd44: r = i_sto(R_D2);
      7'd45: r = i_clr();
      7'd46: r = i_mac(SRC_A01, SRC_B1, 1'b0);
      7'd47: r = i_sto(R_A01);
      7'd48: r = i_clr();
      7'd49: r = i_mac(SRC_A02, SRC_B2, 1'b0);
      7'd50: r = i_sto(R_A02);
      7'd51: r = i_clr();
      7'd52: r = i_mac(SRC_A12, SRC_B2, 1'b0);
      7'd53: r = i_sto(R_A12);
      7'd54: r = i_clr();
      7'd55: r = i_mac(SRC_A00, SRC_B0, 1'b0);
      7'd56: r = i_mac(SRC_A11, SRC_B1, 1'b0);
      7'd57: r = i_mac(SRC_D2, SRC_B2, 1'b0);
      7'd58: r = i_mac(SRC_A01, SRC_B0X2, 1'b0);
      7'd59: r = i_mac(SRC_A02, SRC_B0X2, 1'b0);
      7'd60: r = i_mac(SRC_A12, SRC_B1X2, 1'b0);
      7'd61: r = i_mac(SRC_D3, SRC_S0X2, 1'b0);
      7'd62: r = i_div();
      7'd63: r = i_emit(CND_K_LOW, OUT_LOWC);
      default: r = i_emit(CND_ALWAYS, OUT_KEPT);
    endcase
    return r;
  endfunction

endpackage

FILE: design/kpr_datapath.sv
// ----------------------------------------------------------------------------
// kpr_datapath
// Sample store, configuration registers, bit-serial multiply-accumulate,
// restoring divider and output payload register.
// ----------------------------------------------------------------------------
module kpr_datapath #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  logic [4:0]                    sample_index,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  kpr_pkg::cmd_t                 cmd,
  output kpr_pkg::status_t              status,
  output logic [1:0]                    outcome,
  output logic [15:0]                   contrast
);

  localparam int SB = SAMPLE_BITS;
  localparam int NW = (SB + 3 > 17) ? SB + 3 : 17;
  localparam int BW = 4 * SB + 12;
  localparam int DW = BW + kpr_pkg::QUOT_BITS - 1;
  localparam int CW = $clog2(NW);

  logic [SB-1:0]        samples [kpr_pkg::NUM_SAMPLES];
  logic signed [NW-1:0] ext [kpr_pkg::NUM_SAMPLES];
  logic [kpr_pkg::EDGE_BITS-1:0] edge_thr;
  logic [kpr_pkg::CON_BITS-1:0]  con_thr;

  logic signed [NW-1:0] dxx, dyy, dxy, dxs, dys, dss, b0, b1, b2, tr;
  logic signed [NW-1:0] narrow_a, narrow_m;
  logic signed [BW-1:0] wide_a;
  logic signed [BW-1:0] regs [kpr_pkg::R_COUNT];
  logic signed [BW-1:0] acc, areg;
  logic [NW-1:0]        mreg;
  logic                 neg, busy, is_div;
  logic [CW-1:0]        cnt;
  logic [BW-1:0]        rem;
  logic [DW-1:0]        dv;
  logic [kpr_pkg::QUOT_BITS-1:0] quot;
  logic signed [BW-1:0] d3x2, abs_d3x2, abs_acc;
  logic                 last_step, sub;

  // hold samples; an index beyond the neighborhood stores nothing
  always_ff @(posedge clk) begin
    if (in_accept && sample_index < 5'(kpr_pkg::NUM_SAMPLES)) begin
      samples[sample_index] <= sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_thr <= 16'd3098;
      con_thr  <= 15'd492;
    end else if (cfg_write) begin
      if (cfg_index == kpr_pkg::CFG_EDGE) begin
        edge_thr <= cfg_data;
      end else if (cfg_index == kpr_pkg::CFG_CONTRAST) begin
        con_thr <= cfg_data[kpr_pkg::CON_BITS-1:0];
      end
    end
  end

  for (genvar g = 0; g < kpr_pkg::NUM_SAMPLES; g++) begin : g_ext
    assign ext[g] = {{(NW-SB){samples[g][SB-1]}}, samples[g]};
  end

  assign dxx = ext[1] + ext[2] - (ext[0] <<< 1);
  assign dyy = ext[3] + ext[4] - (ext[0] <<< 1);
  assign dxy = ext[5] - ext[6] - ext[7] + ext[8];
  assign dxs = ext[14] - ext[15] + ext[19] - ext[20];
  assign dys = ext[16] - ext[17] + ext[21] - ext[22];
  assign dss = ext[23] - ext[24] + (ext[0] <<< 1);
  assign b0  = ext[10] - ext[9];
  assign b1  = ext[12] - ext[11];
  assign b2  = ext[18] - ext[13];
  assign tr  = dxx + dyy;

  function automatic logic signed [NW-1:0] pick_narrow(
    input logic [3:0] code,
    input logic signed [NW-1:0] v_dxx, input logic signed [NW-1:0] v_dyy,
    input logic signed [NW-1:0] v_dxy, input logic signed [NW-1:0] v_dxs,
    input logic signed [NW-1:0] v_dys, input logic signed [NW-1:0] v_dss,
    input logic signed [NW-1:0] v_b0, input logic signed [NW-1:0] v_b1,
    input logic signed [NW-1:0] v_b2, input logic signed [NW-1:0] v_tr,
    input logic [kpr_pkg::EDGE_BITS-1:0] v_et, input logic signed [NW-1:0] v_s0);
    logic signed [NW-1:0] r;
    unique case ({1'b0, code})
      kpr_pkg::SRC_DXX:  r = v_dxx;
      kpr_pkg::SRC_DYY:  r = v_dyy;
      kpr_pkg::SRC_DXY:  r = v_dxy;
      kpr_pkg::SRC_DXS:  r = v_dxs;
      kpr_pkg::SRC_DYS:  r = v_dys;
      kpr_pkg::SRC_DSS:  r = v_dss;
      kpr_pkg::SRC_B0:   r = v_b0;
      kpr_pkg::SRC_B1:   r = v_b1;
      kpr_pkg::SRC_B2:   r = v_b2;
      kpr_pkg::SRC_TR:   r = v_tr;
      kpr_pkg::SRC_ET:   r = {{(NW-kpr_pkg::EDGE_BITS){1'b0}}, v_et};
      kpr_pkg::SRC_S0X2: r = v_s0 <<< 1;
      kpr_pkg::SRC_B0X2: r = v_b0 <<< 1;
      kpr_pkg::SRC_B1X2: r = v_b1 <<< 1;
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign narrow_a = pick_narrow(cmd.ins.src[3:0], dxx, dyy, dxy, dxs, dys, dss,
                                b0, b1, b2, tr, edge_thr, ext[0]);
  assign narrow_m = pick_narrow(cmd.ins.msel, dxx, dyy, dxy, dxs, dys, dss,
                                b0, b1, b2, tr, edge_thr, ext[0]);

  always_comb begin
    if (cmd.ins.src == kpr_pkg::SRC_TRSH) begin
      wide_a = {{(BW-NW){tr[NW-1]}}, tr} <<< 8;
    end else if (cmd.ins.src[4:3] == 2'b10 && cmd.ins.src[2:0] != 3'd7) begin
      wide_a = regs[cmd.ins.src[2:0]];
    end else begin
      wide_a = {{(BW-NW){narrow_a[NW-1]}}, narrow_a};
    end
  end

  assign d3x2      = regs[kpr_pkg::R_D3] <<< 1;
  assign abs_d3x2  = d3x2[BW-1] ? -d3x2 : d3x2;
  assign abs_acc   = acc[BW-1] ? -acc : acc;
  assign last_step = is_div ? (cnt == CW'(kpr_pkg::QUOT_BITS - 1)) : (cnt == CW'(NW - 1));
  // the top multiplier bit carries negative weight
  assign sub       = (cnt == CW'(NW - 1)) ^ neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.go && (cmd.ins.op == kpr_pkg::OP_MAC || cmd.ins.op == kpr_pkg::OP_DIV)) begin
      busy <= 1'b1;
    end else if (busy && last_step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      unique case (cmd.ins.op)
        kpr_pkg::OP_CLR: acc <= '0;
        kpr_pkg::OP_STO: begin
          if (cmd.ins.dst < 3'(kpr_pkg::R_COUNT)) begin
            regs[cmd.ins.dst] <= acc;
          end
        end
        kpr_pkg::OP_MAC: begin
          areg   <= wide_a;
          mreg   <= narrow_m;
          neg    <= cmd.ins.neg;
          is_div <= 1'b0;
          cnt    <= '0;
        end
        kpr_pkg::OP_DIV: begin
          rem    <= abs_acc;
          dv     <= {abs_d3x2, {(kpr_pkg::QUOT_BITS-1){1'b0}}};
          quot   <= '0;
          is_div <= 1'b1;
          cnt    <= '0;
        end
        default: ;
      endcase
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (is_div) begin
        // restore-free step: subtract when the shifted divisor fits
        if ({{(DW-BW){1'b0}}, rem} >= dv) begin
          rem  <= rem - dv[BW-1:0];
          quot <= {quot[kpr_pkg::QUOT_BITS-2:0], 1'b1};
        end else begin
          quot <= {quot[kpr_pkg::QUOT_BITS-2:0], 1'b0};
        end
        dv <= dv >> 1;
      end else begin
        if (mreg[0]) begin
          acc <= sub ? acc - areg : acc + areg;
        end
        areg <= areg <<< 1;
        mreg <= mreg >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      outcome  <= cmd.ins.code;
      contrast <= (cmd.ins.code == kpr_pkg::OUT_KEPT || cmd.ins.code == kpr_pkg::OUT_LOWC)
                  ? quot : '0;
    end
  end

  assign status.done     = busy && last_step;
  assign status.acc_zero = (acc == '0);
  assign status.acc_neg  = acc[BW-1];
  assign status.d2_zero  = (regs[kpr_pkg::R_D2] == '0);
  assign status.d2_pos   = !regs[kpr_pkg::R_D2][BW-1] && (regs[kpr_pkg::R_D2] != '0);
  assign status.tr_nz    = (tr != '0);
  assign status.dxx_zero = (dxx == '0);
  assign status.k_low    = (quot < {1'b0, con_thr});

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.go && (cmd.ins.op == kpr_pkg::OP_MAC || cmd.ins.op == kpr_pkg::OP_DIV) |-> !busy)
    else $error("multi-cycle op started while the unit is busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    status.done |=> !busy)
    else $error("unit stayed busy after its last step");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !last_step |=> busy)
    else $error("unit went idle before its last step");

endmodule

FILE: design/kpr_ctrl.sv
// ----------------------------------------------------------------------------
// kpr_ctrl
// Sequencer: sample intake, microprogram stepping and output register control.
// ----------------------------------------------------------------------------
module kpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  kpr_pkg::status_t status,
  output kpr_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                  state, state_next;
  logic [kpr_pkg::PC_BITS-1:0] pc, pc_next;
  kpr_pkg::instr_t             ins;
  logic                        cond_true, out_free, accept;

  assign ins      = kpr_pkg::prog(pc);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (ins.cond)
      kpr_pkg::CND_ALWAYS:   cond_true = 1'b1;
      kpr_pkg::CND_FLAT:     cond_true = status.d2_zero && status.tr_nz;
      kpr_pkg::CND_EDGE:     cond_true = status.d2_pos && !status.acc_neg;
      kpr_pkg::CND_PIVOT:    cond_true = status.dxx_zero || status.d2_zero;
      kpr_pkg::CND_ACC_ZERO: cond_true = status.acc_zero;
      kpr_pkg::CND_K_LOW:    cond_true = status.k_low;
      default:               cond_true = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    pc_next      = pc;
    cmd.go       = 1'b0;
    cmd.load_out = 1'b0;
    cmd.ins      = ins;
    unique case (state)
      ST_IDLE: begin
        if (accept && last) begin
          pc_next    = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (ins.op)
          kpr_pkg::OP_MAC, kpr_pkg::OP_DIV: begin
            cmd.go     = 1'b1;
            state_next = ST_WAIT;
          end
          kpr_pkg::OP_EMIT: begin
            if (cond_true) begin
              state_next = ST_OUT;
            end else begin
              pc_next = pc + 1'b1;
            end
          end
          default: begin
            cmd.go  = 1'b1;
            pc_next = pc + 1'b1;
          end
        endcase
      end
      ST_WAIT: begin
        if (status.done) begin
          pc_next    = pc + 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> in_stall)
    else $error("input not held off after the final sample");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result register overwritten before transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

FILE: design/keypoint_refine_filter.sv
// ----------------------------------------------------------------------------
// keypoint_refine_filter
// Keypoint edge test, quadratic refinement and contrast rejection.
// ----------------------------------------------------------------------------
// Samples arrive one per cycle, each transfer carrying its neighborhood index;
// the transfer with last set starts evaluation and the input stalls until the
// result has been moved into the output register. Evaluation runs a fixed
// microprogram on one shared bit-serial multiply-accumulate unit (NW-bit
// multiplier, NW = max(SAMPLE_BITS+3, 17)) and a 16-step restoring divider;
// early rejections end the program sooner. The result register frees the
// block as soon as a result is parked there, so the next keypoint loads
// while the previous result waits for its transfer. Every product is exact;
// contrast is the floor of the interpolated magnitude as an unsigned Q16.0
// integer, saturated to 65535, and is zero for edge and zero-pivot outcomes.
// Configuration writes are always ready and must only happen while idle.
// ----------------------------------------------------------------------------
module keypoint_refine_filter #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [4:0]                    sample_index,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    outcome,
  output logic [15:0]                   contrast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);

  kpr_pkg::cmd_t    cmd;
  kpr_pkg::status_t status;
  logic             in_accept;

  // config port never backpressures
  assign cfg_ready = 1'b1;
  // a sample transfers when valid meets an unstalled input
  assign in_accept = in_valid && !in_stall;

  kpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  kpr_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (in_accept),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .outcome      (outcome),
    .contrast     (contrast)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypoint_refine_filter testbench
// Streams neighborhood samples into the filter, predicts every edge, pivot
// and contrast verdict with exact wide integer arithmetic and checks each
// result transfer in order. Thresholds are changed between phases.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [4:0]         index;
    logic signed [15:0] value;
    logic               last;
  } sample_t;

  typedef struct {
    logic [1:0]  outcome;
    logic [15:0] contrast;
  } verdict_t;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 1500;
  localparam int HOLD_CYCLES   = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [4:0]         sample_index = '0;
  logic signed [15:0] sample_value = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         outcome;
  logic [15:0]        contrast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  keypoint_refine_filter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_index(sample_index), .sample_value(sample_value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .outcome(outcome), .contrast(contrast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the filter state
  logic signed [15:0] shadow_store [kpr_pkg::NUM_SAMPLES];
  logic [15:0]        shadow_edge_thr = 16'd3098;
  logic [14:0]        shadow_con_thr  = 15'd492;

  sample_t  pending_samples[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  bit       send_burst = 1'b0;
  bit       recv_burst = 1'b0;

  // Work out the verdict for the samples currently held.
  function automatic verdict_t judge_keypoint();
    verdict_t v;
    wide_t s[kpr_pkg::NUM_SAMPLES];
    wide_t dxx, dyy, dxy, tr, d2, b0, b1, b2, dss, dxs, dys;
    wide_t a00, a11, a01, a02, a12, d3, q, num, n, dn, k;
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++) s[i] = wide_t'(shadow_store[i]);
    v.outcome  = kpr_pkg::OUT_KEPT;
    v.contrast = '0;
    dxx = s[1] + s[2] - 2 * s[0];
    dyy = s[3] + s[4] - 2 * s[0];
    dxy = s[5] - s[6] - s[7] + s[8];
    tr  = dxx + dyy;
    d2  = dxx * dyy - dxy * dxy;
    if (d2 > 0) begin
      if (tr * tr * 256 >= wide_t'(shadow_edge_thr) * d2) begin
        v.outcome = kpr_pkg::OUT_EDGE;
        return v;
      end
    end else if (d2 == 0 && tr != 0) begin
      v.outcome = kpr_pkg::OUT_EDGE;
      return v;
    end
    b0  = s[10] - s[9];
    b1  = s[12] - s[11];
    b2  = s[18] - s[13];
    dss = s[23] - s[24] + 2 * s[0];
    dxs = s[14] - s[15] + s[19] - s[20];
    dys = s[16] - s[17] + s[21] - s[22];
    if (dxx == 0 || d2 == 0) begin
      v.outcome = kpr_pkg::OUT_PIVOT;
      return v;
    end
    a00 = dyy * dss - dys * dys;
    a11 = dxx * dss - dxs * dxs;
    a01 = dxs * dys - dxy * dss;
    a02 = dxy * dys - dxs * dyy;
    a12 = dxy * dxs - dxx * dys;
    d3  = dxx * a00 + dxy * a01 + dxs * a02;
    if (d3 == 0) begin
      v.outcome = kpr_pkg::OUT_PIVOT;
      return v;
    end
    q = b0 * b0 * a00 + b1 * b1 * a11 + b2 * b2 * d2
      + 2 * (b0 * b1 * a01 + b0 * b2 * a02 + b1 * b2 * a12);
    num = 2 * s[0] * d3 + q;
    n   = (num < 0) ? -num : num;
    dn  = (d3 < 0) ? -2 * d3 : 2 * d3;
    k   = n / dn;
    v.contrast = (k > 65535) ? 16'hFFFF : k[15:0];
    if (n < wide_t'(shadow_con_thr) * dn) v.outcome = kpr_pkg::OUT_LOWC;
    return v;
  endfunction

  // ---------------- input driver ----------------
  logic in_taken = 1'b0;
  int   send_gap = 0;

  // Track every accepted sample transfer; predict on the one with last set.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      if (sample_index < kpr_pkg::NUM_SAMPLES) shadow_store[sample_index] = sample_value;
      if (last) expected_verdicts.push_back(judge_keypoint());
    end
  end

  always @(negedge clk) begin
    sample_t nxt;
    if (rst || (in_valid && !in_taken)) begin
      // hold the offered sample until it is taken
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_samples.size() > 0) begin
      nxt = pending_samples.pop_front();
      in_valid     <= 1'b1;
      sample_index <= nxt.index;
      sample_value <= nxt.value;
      last         <= nxt.last;
      send_gap     <= send_burst ? 0 : $urandom_range(0, 11);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------- result monitor ----------------
  logic out_taken = 1'b0;
  int   recv_wait = 0;
  int   hold_left = 0;
  int   verdicts_seen = 0;

  always @(posedge clk) begin
    verdict_t want;
    out_taken <= out_valid && !out_stall;
    if (!rst && out_valid && !out_stall) begin
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result outcome=%0d contrast=%0d", $time, outcome, contrast);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (outcome !== want.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
          errors++;
        end
        if (contrast !== want.contrast) begin
          $display("%0t: contrast expected %0d actual %0d", $time, want.contrast, contrast);
          errors++;
        end
      end
    end
  end

  // Stall the output; once, hold off long enough for the filter to back up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (verdicts_seen == 20 && out_taken) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (out_taken) begin
      recv_wait <= recv_burst ? 0 : $urandom_range(0, 11);
      out_stall <= !recv_burst;
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return -16'sh8000;
    return x[15:0];
  endfunction

  task automatic queue_sample(int idx, logic signed [15:0] val, bit fin);
    sample_t s;
    s.index = idx[4:0];
    s.value = val;
    s.last  = fin;
    pending_samples.push_back(s);
  endtask

  // Queue a full neighborhood in shuffled order, last on the final one.
  task automatic queue_keypoint(logic signed [15:0] vals [kpr_pkg::NUM_SAMPLES]);
    int order[kpr_pkg::NUM_SAMPLES];
    int j, t;
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++) order[i] = i;
    for (int i = kpr_pkg::NUM_SAMPLES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++)
      queue_sample(order[i], vals[order[i]], i == kpr_pkg::NUM_SAMPLES - 1);
  endtask

  // Peak-shaped neighborhood: neighbors fall away from the center.
  task automatic queue_peak();
    logic signed [15:0] vals [kpr_pkg::NUM_SAMPLES];
    longint c, spread, dir;
    c = longint'($urandom_range(0, 60000)) - 30000;
    dir = (c < 0) ? -1 : 1;
    spread = $urandom_range(0, 3) == 0 ? $urandom_range(1, 16000) : $urandom_range(1, 1500);
    vals[0] = clamp16(c);
    for (int i = 1; i < kpr_pkg::NUM_SAMPLES; i++)
      vals[i] = clamp16(c - dir * longint'($urandom_range(0, spread)));
    queue_keypoint(vals);
  endtask

  task automatic queue_noise_keypoint();
    logic signed [15:0] vals [kpr_pkg::NUM_SAMPLES];
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++) vals[i] = 16'($urandom());
    queue_keypoint(vals);
  endtask

  // Partial update: a few samples (some out of range), then evaluate.
  task automatic queue_patch();
    int cnt;
    cnt = $urandom_range(1, 5);
    for (int i = 0; i < cnt; i++)
      queue_sample($urandom_range(0, 7) == 0 ? $urandom_range(25, 31) : $urandom_range(0, 24),
                   16'($urandom()), i == cnt - 1);
  endtask

  task automatic fill_random(int budget);
    int r;
    while (budget > 0) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        queue_peak();
        budget -= kpr_pkg::NUM_SAMPLES;
      end else if (r < 7) begin
        queue_noise_keypoint();
        budget -= kpr_pkg::NUM_SAMPLES;
      end else if (r < 9) begin
        queue_patch();
        budget -= 3;
      end else begin
        // stray samples with no evaluation
        queue_sample($urandom_range(0, 31), 16'($urandom()), 1'b0);
      end
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == kpr_pkg::CFG_EDGE) shadow_edge_thr = data;
    else if (idx == kpr_pkg::CFG_CONTRAST) shadow_con_thr = data[14:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every sample is taken and every verdict has arrived.
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] vals [kpr_pkg::NUM_SAMPLES];
    logic [15:0] edge_set [4];
    logic [14:0] con_set [4];
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++) shadow_store[i] = '0;
    edge_set = '{16'd0, 16'hFFFF, 16'd3098, 16'd0};
    con_set  = '{15'd0, 15'h7FFF, 15'd492, 15'd0};
    edge_set[3] = 16'($urandom());
    con_set[3]  = 15'($urandom());
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme values everywhere, then flat and degenerate cases.
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++) vals[i] = i[0] ? 16'sh7FFF : -16'sh8000;
    queue_keypoint(vals);
    drain();
    // flat neighborhood: every sum but dss zero, zero pivot
    for (int i = 0; i < kpr_pkg::NUM_SAMPLES; i++) vals[i] = 16'sd1000;
    queue_keypoint(vals);
    // zero Dxx with a cross term: not an edge, zero pivot
    queue_sample(5, 16'sd1200, 1'b0);
    // out-of-range index still evaluates the stored samples
    queue_sample(27, 16'sh7FFF, 1'b1);
    // zero determinant after a nonzero Dxx pivot: dxs=dys=dss=0
    queue_sample(5, 16'sd1000, 1'b0);
    queue_sample(1, 16'sd900, 1'b0);
    queue_sample(3, 16'sd900, 1'b0);
    queue_sample(23, 16'sd0, 1'b0);
    queue_sample(24, 16'sd2000, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_register(kpr_pkg::CFG_EDGE, edge_set[p]);
      write_register(kpr_pkg::CFG_CONTRAST, {1'b0, con_set[p]});
      if (p == 2) write_register(CFG_SPARE, 16'($urandom()));
      send_burst = (p == 1);
      recv_burst = (p == 2);
      fill_random(410);
      drain();
    end

    if (errors == 0) begin
      $display("keypoint_refine_filter verification clean");
    end else begin
      $display("keypoint_refine_filter verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("keypoint_refine_filter verification failed");
    $finish;
  end

endmodule
